FILE: design/spfo_pkg.sv
// ----------------------------------------------------------------------------
// spfo_pkg
// Shared types and constants for the stereo PCM overwrite ring FIFO.
// ----------------------------------------------------------------------------
package spfo_pkg;

  // fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int FRAME_W    = 2 * SAMPLE_W;
  localparam int CAP_W      = 13;
  localparam int CNT_W      = 32;
  localparam int MODE_W     = 2;
  localparam int DEPTH_DEF  = 4096;

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

  // request codes
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

  // per-request status handed from ring control to the output stage
  typedef struct packed {
    logic             got;
    logic             under;
    logic             over;
    logic [CAP_W-1:0] fill;
    logic [CNT_W-1:0] written;
    logic [CNT_W-1:0] rd;
    logic [CNT_W-1:0] dropped;
    logic [CNT_W-1:0] underrun;
  } spfo_meta_t;

endpackage

FILE: design/spfo_ram.sv
// ----------------------------------------------------------------------------
// spfo_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spfo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/spfo_ctrl.sv
// ----------------------------------------------------------------------------
// spfo_ctrl
// Ring control: capacity register, pointers, fill count, event counters and
// the frame store access for each accepted request.
// ----------------------------------------------------------------------------
module spfo_ctrl #(
  parameter int DEPTH = spfo_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request side
  input  logic                          accept,
  input  logic [spfo_pkg::MODE_W-1:0]   mode,
  input  logic [spfo_pkg::FRAME_W-1:0]  frame_in,
  output spfo_pkg::spfo_meta_t          meta,
  // frame store
  output logic                          ram_we,
  output logic [$clog2(DEPTH)-1:0]      ram_waddr,
  output logic [spfo_pkg::FRAME_W-1:0]  ram_wdata,
  output logic                          ram_re,
  output logic [$clog2(DEPTH)-1:0]      ram_raddr,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata
);

  import spfo_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int KW = (PW + 1 > CAP_W) ? PW + 1 : CAP_W;

  logic [CAP_W-1:0] capacity;
  logic [PW-1:0]    rptr, rptr_next;
  logic [PW-1:0]    wptr, wptr_next;
  logic [KW-1:0]    held, held_next;
  logic [CNT_W-1:0] cnt_wr, cnt_wr_next;
  logic [CNT_W-1:0] cnt_rd, cnt_rd_next;
  logic [CNT_W-1:0] cnt_drop, cnt_drop_next;
  logic [CNT_W-1:0] cnt_under, cnt_under_next;
  logic [KW-1:0]    cap_eff;
  logic             cfg_wr;
  logic             got, under, over;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                            input logic [KW-1:0] cap);
    logic [KW-1:0] n;
    n = KW'(p) + KW'(1);
    return (n >= cap) ? '0 : n[PW-1:0];
  endfunction

  // capacity in use, clamped to 1..DEPTH
  always_comb begin
    if (capacity == '0) begin
      cap_eff = KW'(1);
    end else if (KW'(capacity) > KW'(DEPTH)) begin
      cap_eff = KW'(DEPTH);
    end else begin
      cap_eff = KW'(capacity);
    end
  end

  // configuration write and readback
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? 32'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // per-request ring update
  always_comb begin
    rptr_next      = rptr;
    wptr_next      = wptr;
    held_next      = held;
    cnt_wr_next    = cnt_wr;
    cnt_rd_next    = cnt_rd;
    cnt_drop_next  = cnt_drop;
    cnt_under_next = cnt_under;
    got            = 1'b0;
    under          = 1'b0;
    over           = 1'b0;
    ram_we         = 1'b0;
    case (mode)
      MODE_WRITE: begin
        ram_we      = accept;
        wptr_next   = advance(wptr, cap_eff);
        cnt_wr_next = cnt_wr + 1'b1;
        if (held >= cap_eff) begin
          // full: drop the oldest frame, fill level stays
          over          = 1'b1;
          rptr_next     = advance(rptr, cap_eff);
          cnt_drop_next = cnt_drop + 1'b1;
        end else begin
          held_next = held + 1'b1;
        end
      end
      MODE_READ: begin
        if (held == '0) begin
          under          = 1'b1;
          cnt_under_next = cnt_under + 1'b1;
        end else begin
          got         = 1'b1;
          rptr_next   = advance(rptr, cap_eff);
          held_next   = held - 1'b1;
          cnt_rd_next = cnt_rd + 1'b1;
        end
      end
      MODE_FLUSH: begin
        rptr_next = '0;
        wptr_next = '0;
        held_next = '0;
      end
      default: begin
      end
    endcase
  end

  // store access: frame read issued with the request, data next cycle
  assign ram_waddr = wptr;
  assign ram_wdata = frame_in;
  assign ram_re    = accept;
  assign ram_raddr = rptr;

  // pointer and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rptr      <= '0;
      wptr      <= '0;
      held      <= '0;
      cnt_wr    <= '0;
      cnt_rd    <= '0;
      cnt_drop  <= '0;
      cnt_under <= '0;
    end else if (cfg_wr) begin
      rptr <= '0;
      wptr <= '0;
      held <= '0;
    end else if (accept) begin
      rptr      <= rptr_next;
      wptr      <= wptr_next;
      held      <= held_next;
      cnt_wr    <= cnt_wr_next;
      cnt_rd    <= cnt_rd_next;
      cnt_drop  <= cnt_drop_next;
      cnt_under <= cnt_under_next;
    end
  end

  // status of this request
  always_comb begin
    meta.got      = got;
    meta.under    = under;
    meta.over     = over;
    meta.fill     = held_next[CAP_W-1:0];
    meta.written  = cnt_wr_next;
    meta.rd       = cnt_rd_next;
    meta.dropped  = cnt_drop_next;
    meta.underrun = cnt_under_next;
  end

endmodule

FILE: design/spfo_out.sv
// ----------------------------------------------------------------------------
// spfo_out
// Output side: a stage that waits for the store read data, then the result
// register; the stage doubles as skid storage while the result is stalled.
// ----------------------------------------------------------------------------
module spfo_out (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  spfo_pkg::spfo_meta_t          meta_in,
  input  logic [spfo_pkg::FRAME_W-1:0]  ram_rdata,
  output logic                          take,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spfo_pkg::FRAME_W-1:0]  out_frame,
  output spfo_pkg::spfo_meta_t          out_meta
);

  import spfo_pkg::*;

  logic       s1_valid;
  spfo_meta_t s1_meta;
  logic       s1_move;

  assign s1_move = s1_valid & (~out_valid | out_ready);
  assign take    = ~s1_valid | s1_move;

  // handshake state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (push) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (push) begin
      s1_meta <= meta_in;
    end
    if (s1_move) begin
      out_meta  <= s1_meta;
      out_frame <= s1_meta.got ? ram_rdata : '0;
    end
  end

endmodule

FILE: design/stereo_pcm_ring_fifo_overwrite.sv
// ----------------------------------------------------------------------------
// stereo_pcm_ring_fifo_overwrite
// Ring FIFO of stereo 16-bit frames with overwrite of the oldest on full.
// ----------------------------------------------------------------------------
// Path: a taken request reads the frame store and loads the wait stage, which
// then moves into the result register whenever the result is not stalled.
// Throughput: one request per cycle unless the result stream stalls; the frame
// store has one write and one read port, so a write and the next read never collide.
// Reset: pointers, fill count, counters and capacity (4096) clear at once;
// the frame store is not cleared and there is no clearing pass.
// ----------------------------------------------------------------------------
module stereo_pcm_ring_fifo_overwrite #(
  parameter int DEPTH = spfo_pkg::DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // request stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // in_left[15:0], in_right[31:16]
  input  logic [1:0]   s_tuser,   // mode[1:0]
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [175:0] m_tdata,   // out_left[15:0], out_right[31:16],
                                  // fill_level[44:32], written_total[76:45],
                                  // read_total[108:77], dropped_total[140:109],
                                  // underrun_total[172:141], zero[175:173]
  output logic [2:0]   m_tuser,   // frame_returned[0], underrun_flag[1],
                                  // overwrite_flag[2]
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  import spfo_pkg::*;

  localparam int PW = $clog2(DEPTH);

  logic                accept;
  logic                take;
  spfo_meta_t          meta;
  spfo_meta_t          out_meta;
  logic [FRAME_W-1:0]  out_frame;
  logic                ram_we;
  logic [PW-1:0]       ram_waddr;
  logic [FRAME_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [PW-1:0]       ram_raddr;
  logic [FRAME_W-1:0]  ram_rdata;

  // no request is taken while reset is held
  assign pready   = 1'b1;
  assign s_tready = take & ~rst;
  assign accept   = s_tvalid & s_tready;

  spfo_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .mode      (s_tuser),
    .frame_in  (s_tdata),
    .meta      (meta),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
  );

  spfo_ram #(.WIDTH(FRAME_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  spfo_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .meta_in   (meta),
    .ram_rdata (ram_rdata),
    .take      (take),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_frame (out_frame),
    .out_meta  (out_meta)
  );

  // result packing
  assign m_tdata = {3'b000, out_meta.underrun, out_meta.dropped, out_meta.rd,
                    out_meta.written, out_meta.fill, out_frame};
  assign m_tuser = {out_meta.over, out_meta.under, out_meta.got};

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stereo PCM overwrite ring FIFO. A queue of
// requests feeds a stream driver, and a request-level ring model predicts each
// result: frame order, overwrite of the oldest frame when full, underrun on
// empty, flush and the wrapping totals. A monitor compares every result
// field by field. The capacity register is changed over the APB port
// between phases, and both stream sides back off at random.
// ----------------------------------------------------------------------------
module tb_top;
  import spfo_pkg::*;

  localparam int RING_DEPTH = DEPTH_DEF;
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
  localparam logic [2:0] ADDR_CAPACITY = 3'd0;
  localparam int IDLE_PCT = 18;
  localparam int MAX_LOGGED = 40;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
  } pcm_req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                returned;
    logic                under;
    logic                over;
    logic [CAP_W-1:0]    fill;
    logic [CNT_W-1:0]    written;
    logic [CNT_W-1:0]    rd;
    logic [CNT_W-1:0]    dropped;
    logic [CNT_W-1:0]    underrun;
  } ring_status_t;

  // dut signals, known from time zero
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;   // in_left[15:0], in_right[31:16]
  logic [1:0]   s_tuser = '0;   // mode[1:0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [175:0] m_tdata;        // out_left, out_right, fill_level, written_total,
                                // read_total, dropped_total, underrun_total
  logic [2:0]   m_tuser;        // frame_returned, underrun_flag, overwrite_flag
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  // bench state
  pcm_req_t     pcm_pending[$];
  ring_status_t status_due[$];
  bit           steady = 1'b0;
  int           error_count = 0;
  int           requests_taken = 0;
  int           results_seen = 0;
  int           overwrites_seen = 0;
  int           underruns_seen = 0;
  int           frames_seen = 0;
  int           capacity_writes = 0;

  // ring model state
  logic [FRAME_W-1:0] ring_mem [RING_DEPTH];
  int unsigned        rd_ptr = 0;
  int unsigned        wr_ptr = 0;
  int unsigned        held = 0;
  logic [CNT_W-1:0]   cnt_wr = '0;
  logic [CNT_W-1:0]   cnt_rd = '0;
  logic [CNT_W-1:0]   cnt_drop = '0;
  logic [CNT_W-1:0]   cnt_under = '0;
  logic [CAP_W-1:0]   cap_reg = CAP_RESET;

  stereo_pcm_ring_fifo_overwrite #(
    .DEPTH(RING_DEPTH)
  ) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ring model: advance the state by one request and return its status
  function automatic ring_status_t next_ring_status(pcm_req_t req);
    ring_status_t st;
    int unsigned  cap;
    cap = (cap_reg == 0) ? 1 : ((cap_reg > RING_DEPTH) ? RING_DEPTH : cap_reg);
    st = '0;
    // stale pointers beyond the capacity in use empty the ring
    if (rd_ptr >= cap || wr_ptr >= cap || held > cap) begin
      rd_ptr = 0;
      wr_ptr = 0;
      held = 0;
    end
    case (req.mode)
      MODE_WRITE: begin
        if (held >= cap) begin
          rd_ptr = (rd_ptr + 1 >= cap) ? 0 : rd_ptr + 1;
          held--;
          cnt_drop++;
          st.over = 1'b1;
        end
        ring_mem[wr_ptr] = {req.right, req.left};
        wr_ptr = (wr_ptr + 1 >= cap) ? 0 : wr_ptr + 1;
        held++;
        cnt_wr++;
      end
      MODE_READ: begin
        if (held == 0) begin
          cnt_under++;
          st.under = 1'b1;
        end else begin
          {st.right, st.left} = ring_mem[rd_ptr];
          rd_ptr = (rd_ptr + 1 >= cap) ? 0 : rd_ptr + 1;
          held--;
          cnt_rd++;
          st.returned = 1'b1;
        end
      end
      MODE_FLUSH: begin
        rd_ptr = 0;
        wr_ptr = 0;
        held = 0;
      end
      default: ;
    endcase
    st.fill = held[CAP_W-1:0];
    st.written = cnt_wr;
    st.rd = cnt_rd;
    st.dropped = cnt_drop;
    st.underrun = cnt_under;
    return st;
  endfunction

  task automatic log_mismatch(string what, logic [31:0] seen, logic [31:0] want);
    error_count++;
    if (error_count <= MAX_LOGGED)
      $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, seen, want);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        status_due.push_back(next_ring_status('{s_tuser, s_tdata[15:0], s_tdata[31:16]}));
        requests_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (pcm_pending.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          pcm_req_t nxt;
          nxt = pcm_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {nxt.right, nxt.left};
          s_tuser <= nxt.mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      if (m_tvalid && m_tready) begin
        ring_status_t seen;
        ring_status_t want;
        seen.left = m_tdata[15:0];
        seen.right = m_tdata[31:16];
        seen.fill = m_tdata[44:32];
        seen.written = m_tdata[76:45];
        seen.rd = m_tdata[108:77];
        seen.dropped = m_tdata[140:109];
        seen.underrun = m_tdata[172:141];
        {seen.over, seen.under, seen.returned} = m_tuser;
        results_seen++;
        overwrites_seen += seen.over;
        underruns_seen += seen.under;
        frames_seen += seen.returned;
        if (status_due.size() == 0) begin
          log_mismatch("result with no request waiting", 1, 0);
        end else begin
          want = status_due.pop_front();
          if (seen.left !== want.left)
            log_mismatch("out_left", 32'(seen.left), 32'(want.left));
          if (seen.right !== want.right)
            log_mismatch("out_right", 32'(seen.right), 32'(want.right));
          if (seen.returned !== want.returned)
            log_mismatch("frame_returned", 32'(seen.returned), 32'(want.returned));
          if (seen.under !== want.under)
            log_mismatch("underrun_flag", 32'(seen.under), 32'(want.under));
          if (seen.over !== want.over)
            log_mismatch("overwrite_flag", 32'(seen.over), 32'(want.over));
          if (seen.fill !== want.fill)
            log_mismatch("fill_level", 32'(seen.fill), 32'(want.fill));
          if (seen.written !== want.written)
            log_mismatch("written_total", seen.written, want.written);
          if (seen.rd !== want.rd) log_mismatch("read_total", seen.rd, want.rd);
          if (seen.dropped !== want.dropped)
            log_mismatch("dropped_total", seen.dropped, want.dropped);
          if (seen.underrun !== want.underrun)
            log_mismatch("underrun_total", seen.underrun, want.underrun);
        end
      end
    end
  end

  task automatic queue_req(logic [MODE_W-1:0] mode, logic [15:0] left, logic [15:0] right);
    pcm_pending.push_back('{mode, left, right});
  endtask

  // random mix; the remainder after writes and reads splits into flush and no-op
  task automatic queue_random(int count, int wr_pct, int rd_pct);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < wr_pct)
        queue_req(MODE_WRITE, 16'($urandom), 16'($urandom));
      else if (pick < wr_pct + rd_pct)
        queue_req(MODE_READ, 16'($urandom), 16'($urandom));
      else if (pick < 96)
        queue_req(MODE_FLUSH, 16'($urandom), 16'($urandom));
      else
        queue_req(MODE_NOP, 16'($urandom), 16'($urandom));
    end
  endtask

  // block until every queued request is taken and every result checked
  task automatic wait_idle();
    do @(posedge clk);
    while (pcm_pending.size() != 0 || s_tvalid || status_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // capacity write: setup phase, then access phase
  task automatic write_capacity(logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_CAPACITY;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // register write empties the ring, counters stay
    cap_reg = value[CAP_W-1:0];
    rd_ptr = 0;
    wr_ptr = 0;
    held = 0;
    capacity_writes++;
  endtask

  // stimulus
  initial begin
    int phase_cap[6] = '{3, 1, 2, 7, 0, 16};
    int phase_len[6] = '{100, 80, 80, 100, 60, 120};
    int phase_wr[6]  = '{55, 50, 60, 45, 55, 65};
    int phase_rd[6]  = '{35, 40, 30, 45, 35, 25};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed at reset capacity: underrun on empty, extreme samples, no-op, order
    queue_req(MODE_READ, 16'h0000, 16'h0000);
    queue_req(MODE_FLUSH, 16'hffff, 16'hffff);
    queue_req(MODE_WRITE, 16'h8000, 16'h7fff);
    queue_req(MODE_WRITE, 16'h7fff, 16'h8000);
    queue_req(MODE_WRITE, 16'h0000, 16'hffff);
    queue_req(MODE_WRITE, 16'hffff, 16'h0000);
    queue_req(MODE_NOP, 16'h5a5a, 16'ha5a5);
    repeat (5) queue_req(MODE_READ, 16'h0000, 16'h0000);
    queue_req(MODE_WRITE, 16'h1234, 16'hedcb);
    queue_req(MODE_WRITE, 16'h8001, 16'h7ffe);
    queue_req(MODE_FLUSH, 16'h0000, 16'h0000);
    queue_req(MODE_READ, 16'hffff, 16'hffff);
    wait_idle();

    // single slot: the second write overwrites the first
    write_capacity(32'd1);
    queue_req(MODE_WRITE, 16'h0001, 16'h0002);
    queue_req(MODE_WRITE, 16'hfffe, 16'hfffd);
    queue_req(MODE_READ, 16'h0000, 16'h0000);
    queue_req(MODE_READ, 16'h0000, 16'h0000);
    queue_req(MODE_NOP, 16'h0000, 16'h0000);
    wait_idle();

    // random phases over several capacities, capacity zero among them
    for (int p = 0; p < 6; p++) begin
      write_capacity(phase_cap[p]);
      steady = (p == 3);
      queue_random(phase_len[p], phase_wr[p], phase_rd[p]);
      wait_idle();
    end

    // above the store depth: saturated to the full depth
    write_capacity(32'h0000_1fff);
    steady = 1'b1;
    for (int i = 0; i < 40; i++)
      queue_req(MODE_WRITE, 16'($urandom), 16'($urandom));
    repeat (6) queue_req(MODE_READ, 16'h0000, 16'h0000);
    queue_req(MODE_FLUSH, 16'h0000, 16'h0000);
    queue_req(MODE_READ, 16'h0000, 16'h0000);
    wait_idle();
    steady = 1'b0;

    // full depth written explicitly, short random tail
    write_capacity(RING_DEPTH);
    queue_random(60, 50, 40);
    wait_idle();
    repeat (10) @(posedge clk);

    if (status_due.size() != 0)
      log_mismatch("results never delivered", 0, status_due.size());
    $display("run: %0d requests, %0d results, %0d capacity settings",
             requests_taken, results_seen, capacity_writes);
    $display("seen: %0d frames returned, %0d overwrites, %0d underruns",
             frames_seen, overwrites_seen, underruns_seen);
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
